FILE: hdl/tlc_pkg.sv
`timescale 1ns / 1ps
package tlc_pkg;

  localparam int BLK_W = 32;
  localparam int STAMP_W = 32;
  localparam int OFFS_W = 4;
  localparam int MAX_WAYS = 16;
  localparam int MAX_WAY_W = 4;

  localparam int L1_SETS_DEF = 64;
  localparam int L1_WAYS_DEF = 4;
  localparam int L2_SETS_DEF = 512;
  localparam int L2_WAYS_DEF = 8;

  localparam logic [OFFS_W-1:0] OFFS_RESET = 4'd6;

  typedef enum logic {
    KIND_READ  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_e;

  typedef struct packed {
    logic               valid;
    logic               dirty;
    logic [BLK_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  typedef struct packed {
    logic             kind;
    logic [BLK_W-1:0] address;
  } in_t;

  typedef struct packed {
    logic             l1_hit;
    logic             l2_hit;
    logic             l1_writeback;
    logic             l2_writeback;
    logic [BLK_W-1:0] l2_victim_block;
  } out_t;

  // least recent stamp, lowest way on a tie; unused ways padded with all ones
  function automatic logic [MAX_WAY_W-1:0] lru_pick(
      input logic [MAX_WAYS-1:0][STAMP_W-1:0] st);
    logic [7:0][STAMP_W-1:0]   s1;
    logic [7:0][MAX_WAY_W-1:0] i1;
    logic [3:0][STAMP_W-1:0]   s2;
    logic [3:0][MAX_WAY_W-1:0] i2;
    logic [1:0][STAMP_W-1:0]   s3;
    logic [1:0][MAX_WAY_W-1:0] i3;
    for (int i = 0; i < 8; i++) begin
      if (st[2*i+1] < st[2*i]) begin
        s1[i] = st[2*i+1];
        i1[i] = MAX_WAY_W'(2*i+1);
      end else begin
        s1[i] = st[2*i];
        i1[i] = MAX_WAY_W'(2*i);
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (s1[2*i+1] < s1[2*i]) begin
        s2[i] = s1[2*i+1];
        i2[i] = i1[2*i+1];
      end else begin
        s2[i] = s1[2*i];
        i2[i] = i1[2*i];
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (s2[2*i+1] < s2[2*i]) begin
        s3[i] = s2[2*i+1];
        i3[i] = i2[2*i+1];
      end else begin
        s3[i] = s2[2*i];
        i3[i] = i2[2*i];
      end
    end
    return (s3[1] < s3[0]) ? i3[1] : i3[0];
  endfunction

endpackage

FILE: hdl/two_level_lru_writeback_cache_model_unit.sv
`timescale 1ns / 1ps
// Tag-only model of a two-level write-back, write-allocate cache. Each item is one read or
// write access; each gives one result with the L1/L2 hit flags, the writeback flags and the
// block number of an evicted dirty L2 line. Each level keeps one set per row of a
// synchronous memory, so an access is a read, modify and write of whole sets. After reset a
// clearing pass writes every set of both levels before the first item is taken. An item is
// indexed, its sets read and evaluated; an L1 miss then updates or fills its L2 set, and a
// dirty L1 victim first updates its copy in L2 (with one extra L2 row read when that copy
// lies in another L2 set). A set count that is not a power of two computes each set index
// in the reciprocal-multiply remainder unit. The result register lets the next item in
// while a result waits.
module two_level_lru_writeback_cache_model_unit #(
  parameter int L1_SETS = tlc_pkg::L1_SETS_DEF,
  parameter int L1_WAYS = tlc_pkg::L1_WAYS_DEF,
  parameter int L2_SETS = tlc_pkg::L2_SETS_DEF,
  parameter int L2_WAYS = tlc_pkg::L2_WAYS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tlc_pkg::OFFS_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  tlc_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output tlc_pkg::out_t             out_data_o
);
  import tlc_pkg::*;

  localparam int L1_IW = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
  localparam int L2_IW = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
  localparam int L1_WW = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
  localparam int L2_WW = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int L1_RW = L1_WAYS * $bits(line_t);
  localparam int L2_RW = L2_WAYS * $bits(line_t);
  localparam int CLR_N = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
  localparam int CLRW  = (CLR_N > 1) ? $clog2(CLR_N) : 1;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_IDX   = 9'b000000100,
    S_RD    = 9'b000001000,
    S_EVAL  = 9'b000010000,
    S_VIDX  = 9'b000100000,
    S_VRD   = 9'b001000000,
    S_FILL2 = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [OFFS_W-1:0]  offs_q;
  logic [STAMP_W-1:0] cnt_q, now_q;
  logic [CLRW-1:0]    clr_q;
  logic               kind_q;
  logic [BLK_W-1:0]   blk_q, vb_q;
  logic [STAMP_W-1:0] vs_q;
  logic [L1_IW-1:0]   l1idx_q;
  logic [L2_IW-1:0]   l2idx_q, vidx_q;
  logic               l2hit_q, l1wb_q;
  out_t               res_q;
  logic               out_valid_q;
  out_t               out_q;

  line_t [L1_WAYS-1:0] l1row_q, l1row_d;
  line_t [L2_WAYS-1:0] l2row_q, l2upd_row, cp_src, cp_row, f2row;
  line_t [L2_WAYS-1:0] l2_rd_row;

  logic [L1_RW-1:0] l1_rdata, l1_wdata;
  logic [L2_RW-1:0] l2_rdata, l2_wdata;
  logic             l1_we, l1_re, l2_we, l2_re;
  logic [L1_IW-1:0] l1_waddr;
  logic [L2_IW-1:0] l2_waddr;

  logic             accept;
  logic [BLK_W-1:0] in_blk;
  logic             u1_busy, u2_busy, u2_start;
  logic [BLK_W-1:0] u2_value;
  logic [L1_IW-1:0] u1_idx;
  logic [L2_IW-1:0] u2_idx;
  logic             clr_last, clr_l1, clr_l2;

  // l1 and l2 lookup and victim choice
  logic                      h1, empty1;
  logic [L1_WW-1:0]          e1w, v1w;
  logic [MAX_WAYS-1:0][STAMP_W-1:0] pad1;
  logic                      h2, empty2;
  logic [L2_WW-1:0]          h2w, e2w, v2w;
  logic [MAX_WAYS-1:0][STAMP_W-1:0] pad2;
  logic                      fill_dirty, wb2;

  function automatic logic l1_miss_wb();
    return !h1 && !empty1 && l1row_q[v1w].dirty;
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_blk     = in_data_i.address >> offs_q;
  assign u2_start   = accept || ((state_q == S_EVAL) && l1_miss_wb());
  assign u2_value   = accept ? in_blk : l1row_q[v1w].tag;
  assign l2_rd_row  = l2_rdata;

  tlc_setidx #(.SETS(L1_SETS), .IW(L1_IW)) u_l1_idx (
    .clk_i, .rst_ni, .start_i(accept), .value_i(in_blk), .busy_o(u1_busy), .idx_o(u1_idx)
  );

  tlc_setidx #(.SETS(L2_SETS), .IW(L2_IW)) u_l2_idx (
    .clk_i, .rst_ni, .start_i(u2_start), .value_i(u2_value), .busy_o(u2_busy),
    .idx_o(u2_idx)
  );

  tlc_ram #(.W(L1_RW), .DEPTH(L1_SETS), .AW(L1_IW)) u_l1_ram (
    .clk_i, .we_i(l1_we), .waddr_i(l1_waddr), .wdata_i(l1_wdata),
    .re_i(l1_re), .raddr_i(u1_idx), .rdata_o(l1_rdata)
  );

  tlc_ram #(.W(L2_RW), .DEPTH(L2_SETS), .AW(L2_IW)) u_l2_ram (
    .clk_i, .we_i(l2_we), .waddr_i(l2_waddr), .wdata_i(l2_wdata),
    .re_i(l2_re), .raddr_i(u2_idx), .rdata_o(l2_rdata)
  );

  always_comb begin
    h1     = 1'b0;
    empty1 = 1'b0;
    e1w    = '0;
    pad1   = '1;
    l1row_d = l1row_q;
    for (int w = 0; w < L1_WAYS; w++) begin
      if (l1row_q[w].valid && (l1row_q[w].tag == blk_q)) begin
        h1 = 1'b1;
        l1row_d[w].stamp = now_q;
        l1row_d[w].dirty = l1row_q[w].dirty | kind_q;
      end
      if (!l1row_q[w].valid) begin
        empty1 = 1'b1;
        e1w    = L1_WW'(w);
      end
      pad1[w] = l1row_q[w].stamp;
    end
    v1w = empty1 ? e1w : L1_WW'(lru_pick(pad1));

    h2  = 1'b0;
    h2w = '0;
    l2upd_row = l2row_q;
    for (int w = 0; w < L2_WAYS; w++) begin
      if (l2row_q[w].valid && (l2row_q[w].tag == blk_q)) begin
        h2  = 1'b1;
        h2w = L2_WW'(w);
        l2upd_row[w].stamp = now_q;
        l2upd_row[w].dirty = l2row_q[w].dirty | kind_q;
      end
    end
    fill_dirty = kind_q | (h2 & l2row_q[h2w].dirty);
    if (!h1) begin
      l1row_d[v1w] = '{valid: 1'b1, dirty: fill_dirty, tag: blk_q, stamp: now_q};
    end
  end

  // copy of a dirty l1 victim in l2 takes its stamp and turns dirty
  always_comb begin
    cp_src = (state_q == S_VRD) ? l2_rd_row : l2row_q;
    cp_row = cp_src;
    for (int w = 0; w < L2_WAYS; w++) begin
      if (cp_src[w].valid && (cp_src[w].tag == vb_q)) begin
        cp_row[w].stamp = vs_q;
        cp_row[w].dirty = 1'b1;
      end
    end
  end

  // l2 fill on a double miss
  always_comb begin
    empty2 = 1'b0;
    e2w    = '0;
    pad2   = '1;
    for (int w = 0; w < L2_WAYS; w++) begin
      if (!l2row_q[w].valid) begin
        empty2 = 1'b1;
        e2w    = L2_WW'(w);
      end
      pad2[w] = l2row_q[w].stamp;
    end
    v2w = empty2 ? e2w : L2_WW'(lru_pick(pad2));
    wb2 = !l2hit_q && !empty2 && l2row_q[v2w].dirty;
    f2row = l2row_q;
    f2row[v2w] = '{valid: 1'b1, dirty: kind_q, tag: blk_q, stamp: now_q};
  end

  // memory ports
  assign clr_last = (clr_q == CLRW'(CLR_N - 1));
  assign clr_l1   = ({1'b0, clr_q} < (CLRW+1)'(L1_SETS));
  assign clr_l2   = ({1'b0, clr_q} < (CLRW+1)'(L2_SETS));

  always_comb begin
    l1_we    = 1'b0;
    l1_waddr = l1idx_q;
    l1_wdata = l1row_d;
    l1_re    = 1'b0;
    l2_we    = 1'b0;
    l2_waddr = l2idx_q;
    l2_wdata = l2hit_q ? l2row_q : f2row;
    l2_re    = 1'b0;
    case (state_q)
      S_CLR: begin
        l1_we    = clr_l1;
        l1_waddr = clr_q[L1_IW-1:0];
        l1_wdata = '0;
        l2_we    = clr_l2;
        l2_waddr = clr_q[L2_IW-1:0];
        l2_wdata = '0;
      end
      S_IDX: begin
        l1_re = !u1_busy && !u2_busy;
        l2_re = !u1_busy && !u2_busy;
      end
      S_EVAL: begin
        l1_we = 1'b1;
      end
      S_VIDX: begin
        l2_re = !u2_busy && (u2_idx != l2idx_q);
      end
      S_VRD: begin
        l2_we    = 1'b1;
        l2_waddr = vidx_q;
        l2_wdata = cp_row;
      end
      S_FILL2: begin
        l2_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:   if (clr_last) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_IDX;
      S_IDX:   if (!u1_busy && !u2_busy) state_d = S_RD;
      S_RD:    state_d = S_EVAL;
      S_EVAL: begin
        if (h1) begin
          state_d = S_DONE;
        end else if (l1_miss_wb()) begin
          state_d = S_VIDX;
        end else begin
          state_d = S_FILL2;
        end
      end
      S_VIDX: begin
        if (!u2_busy) begin
          state_d = (u2_idx == l2idx_q) ? S_FILL2 : S_VRD;
        end
      end
      S_VRD:   state_d = S_FILL2;
      S_FILL2: state_d = S_DONE;
      S_DONE:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      offs_q      <= OFFS_RESET;
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        offs_q <= cfg_wdata_i;
      end
      if (accept) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == S_CLR) begin
        clr_q <= clr_q + 1'b1;
      end
      if ((state_q == S_DONE) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_data_i.kind;
      blk_q  <= in_blk;
      now_q  <= cnt_q;
    end
    if ((state_q == S_IDX) && !u1_busy && !u2_busy) begin
      l1idx_q <= u1_idx;
      l2idx_q <= u2_idx;
    end
    if (state_q == S_RD) begin
      l1row_q <= l1_rdata;
      l2row_q <= l2_rdata;
    end
    if (state_q == S_EVAL) begin
      l2row_q <= l2upd_row;
      l2hit_q <= h2;
      l1wb_q  <= l1_miss_wb();
      vb_q    <= l1row_q[v1w].tag;
      vs_q    <= l1row_q[v1w].stamp;
      res_q   <= '{l1_hit: h1, l2_hit: 1'b0, l1_writeback: 1'b0, l2_writeback: 1'b0,
                   l2_victim_block: '0};
    end
    if ((state_q == S_VIDX) && !u2_busy) begin
      vidx_q <= u2_idx;
      // victim copy lives in the set being worked on
      if (u2_idx == l2idx_q) begin
        l2row_q <= cp_row;
      end
    end
    if (state_q == S_FILL2) begin
      res_q <= '{l1_hit: 1'b0, l2_hit: l2hit_q, l1_writeback: l1wb_q, l2_writeback: wb2,
                 l2_victim_block: wb2 ? l2row_q[v2w].tag : '0};
    end
    if ((state_q == S_DONE) && (!out_valid_q || out_ready_i)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ram_l1_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(l1_we && l1_re))
    else $error("l1 set read and written in the same cycle");

  a_accept_to_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_IDX))
    else $error("accepted item did not start index computation");

  a_hit_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.l1_hit && (out_data_o.l1_writeback ||
                      out_data_o.l2_writeback || out_data_o.l2_hit)))
    else $error("l1 hit reported with a miss-only flag");

  a_l2hit_no_l2wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.l2_hit && out_data_o.l2_writeback))
    else $error("l2 hit reported together with l2 writeback");

endmodule

FILE: hdl/tlc_ram.sv
`timescale 1ns / 1ps
module tlc_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 2,
  parameter int AW    = 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tlc_setidx.sv
`timescale 1ns / 1ps
module tlc_setidx #(
  parameter int SETS = 64,
  parameter int IW   = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [tlc_pkg::BLK_W-1:0] value_i,
  output logic                    busy_o,
  output logic [IW-1:0]           idx_o
);
  import tlc_pkg::*;

  localparam bit POW2 = ((SETS & (SETS - 1)) == 0);

  logic          busy_q;
  logic [IW-1:0] rem_q, rem_d;

  generate
    if (POW2) begin : g_mask
      always_comb begin
        rem_d = '0;
        if (SETS > 1) begin
          rem_d = value_i[IW-1:0];
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          busy_q <= 1'b0;
        end else begin
          busy_q <= start_i;
        end
      end

      always_ff @(posedge clk_i) begin
        if (start_i) begin
          rem_q <= rem_d;
        end
      end
    end else begin : g_recip
      // quotient by reciprocal multiply, remainder by multiply back and subtract
      localparam int SH = $clog2(SETS);
      localparam logic [63:0] MAGIC =
        ((64'd1 << 32) * ((64'd1 << SH) - 64'(SETS))) / 64'(SETS) + 64'd1;
      localparam logic [BLK_W-1:0] MAGIC_W = MAGIC[BLK_W-1:0];
      localparam logic [BLK_W-1:0] DIV = BLK_W'(SETS);

      logic [BLK_W-1:0]   val_q, t1_q, q_q;
      logic [1:0]         ph_q;
      logic [2*BLK_W-1:0] prod;
      logic [BLK_W-1:0]   q_d, back;

      always_comb begin
        prod  = (2*BLK_W)'(val_q) * (2*BLK_W)'(MAGIC_W);
        q_d   = (t1_q + ((val_q - t1_q) >> 1)) >> (SH - 1);
        back  = q_q * DIV;
        rem_d = IW'(val_q - back);
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          busy_q <= 1'b0;
          ph_q   <= '0;
        end else if (start_i) begin
          busy_q <= 1'b1;
          ph_q   <= '0;
        end else if (busy_q) begin
          ph_q <= ph_q + 2'd1;
          if (ph_q == 2'd2) begin
            busy_q <= 1'b0;
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (start_i) begin
          val_q <= value_i;
        end else if (busy_q) begin
          case (ph_q)
            2'd0: begin
              t1_q <= prod[2*BLK_W-1:BLK_W];
            end
            2'd1: begin
              q_q <= q_d;
            end
            default: begin
              rem_q <= rem_d;
            end
          endcase
        end
      end
    end
  endgenerate

  assign busy_o = busy_q;
  assign idx_o  = rem_q;

endmodule
